[hdl/mains_voltage_monitor_defines.svh]
// Assertion helpers for the monitor RTL
`ifndef MAINS_VOLTAGE_MONITOR_DEFINES_SVH
`define MAINS_VOLTAGE_MONITOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MVM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mvm check failed");

// next-cycle implication, checked out of reset
`define MVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mvm check failed");

`endif

[hdl/mvm_pkg.sv]
`timescale 1ns / 1ps

package mvm_pkg;

	// sample and level widths
	localparam int VOLT_BITS = 10;
	localparam int LVL_W     = 10;
	localparam int PCT_W     = 7;
	localparam int TOL_W     = 8;
	localparam int PHASES    = 3;
	localparam int CMP_W     = (VOLT_BITS > LVL_W) ? VOLT_BITS : LVL_W;

	// sample bus: three phases packed, padded to whole bytes
	localparam int S_DATA_W  = ((PHASES * VOLT_BITS + 7) / 8) * 8;

	localparam int OVERVOLT_OFF = 500;
	localparam int PERCENT_DIV  = 100;

	// sum / 3 by reciprocal multiply, exact over the whole sum range
	localparam int SUM_W  = VOLT_BITS + 2;
	localparam int S3     = SUM_W + 1;
	localparam int M3     = (2 ** S3 + PHASES - 1) / PHASES;
	localparam int M3_W   = SUM_W;
	localparam int Q3_W   = SUM_W + M3_W;

	// avg * pct / 100 by reciprocal multiply, exact for any 17-bit product
	localparam int PROD_W  = VOLT_BITS + PCT_W;
	localparam int S100    = PROD_W + 7;
	localparam int M100    = (2 ** S100 + PERCENT_DIV - 1) / PERCENT_DIV;
	localparam int M100_W  = PROD_W + 1;
	localparam int Q100_W  = PROD_W + M100_W;
	localparam int BASE_W  = VOLT_BITS + 1;

	// imbalance limit wraps at 16 bits
	localparam int LIM_W = 16;
	localparam int EXT_W = BASE_W + LIM_W;

	// config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SINGLE_PHASE   = 3'd0,
		CFG_IMB_ENABLE     = 3'd1,
		CFG_UV_FAIL        = 3'd2,
		CFG_UV_RECOVER     = 3'd3,
		CFG_OVERVOLT       = 3'd4,
		CFG_IMB_PERCENT    = 3'd5,
		CFG_IMB_TOLERANCE  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic              single_phase;
		logic              imbalance_enable;
		logic [LVL_W-1:0]  undervolt_fail_level;
		logic [LVL_W-1:0]  undervolt_recover_level;
		logic [LVL_W-1:0]  overvolt_level;
		logic [PCT_W-1:0]  imbalance_percent;
		logic [TOL_W-1:0]  imb_band;
	} cfg_t;

	// what one phase lane finds on a sample
	typedef struct packed {
		logic                 low_fail;
		logic                 low_rec;
		logic                 high;
		logic [VOLT_BITS-1:0] diff;
	} lane_res_t;

	// monitor state, also the result fields
	typedef struct packed {
		logic              imbalanced;
		logic [PHASES-1:0] phase_fail;
		logic              mains_failed;
	} mvm_state_t;

endpackage

[hdl/mains_voltage_monitor.sv]
`timescale 1ns / 1ps
// Pipeline: the accept edge loads sums and lane compares, then average, percent product,
// limit base and merged state are each registered in turn.
// Throughput: 1 request per cycle; a stage holds only while the stage after it is full and
// stalled, so back pressure reaches the input once all five registers are occupied.
// The hysteresis state lives only in the merge stage, so back-to-back samples chain correctly.
// Reset (arst_n low, async): pipeline empty, state and flags zero, registers at defaults.

`include "mains_voltage_monitor_defines.svh"

module mains_voltage_monitor
	import mvm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// config write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// sample stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,  // volt_r, volt_y, volt_b, zero pad
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata   // mains_fail, fail_r, fail_y, fail_b, imbalanced, pad
);

	cfg_t       cfg_q;
	mvm_state_t st_q;
	mvm_state_t st_nxt;

	logic [VOLT_BITS-1:0] volt [PHASES];
	lane_res_t            lane_c [PHASES];

	lane_res_t lane_s1 [PHASES];
	lane_res_t lane_s2 [PHASES];
	lane_res_t lane_s3 [PHASES];
	lane_res_t lane_s4 [PHASES];

	logic [SUM_W-1:0]   sum_s1;
	logic [VOLT_BITS-1:0] avg_s2;
	logic [PROD_W-1:0]  prod_s3;
	logic [BASE_W-1:0]  base_s4;

	logic [Q3_W-1:0]   q3;
	logic [Q100_W-1:0] q100;

	logic v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic rdy2, rdy3, rdy4, rdy5, upd;

	// config registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.single_phase            <= 1'b0;
			cfg_q.imbalance_enable        <= 1'b1;
			cfg_q.undervolt_fail_level    <= LVL_W'(170);
			cfg_q.undervolt_recover_level <= LVL_W'(180);
			cfg_q.overvolt_level          <= LVL_W'(270);
			cfg_q.imbalance_percent       <= PCT_W'(20);
			cfg_q.imb_band                <= TOL_W'(5);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SINGLE_PHASE:  cfg_q.single_phase            <= cfg_data[0];
				CFG_IMB_ENABLE:    cfg_q.imbalance_enable        <= cfg_data[0];
				CFG_UV_FAIL:       cfg_q.undervolt_fail_level    <= cfg_data[LVL_W-1:0];
				CFG_UV_RECOVER:    cfg_q.undervolt_recover_level <= cfg_data[LVL_W-1:0];
				CFG_OVERVOLT:      cfg_q.overvolt_level          <= cfg_data[LVL_W-1:0];
				CFG_IMB_PERCENT:   cfg_q.imbalance_percent       <= cfg_data[PCT_W-1:0];
				CFG_IMB_TOLERANCE: cfg_q.imb_band                <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// unpack the sample
	assign volt[0] = s_tdata[VOLT_BITS-1:0];
	assign volt[1] = s_tdata[2*VOLT_BITS-1:VOLT_BITS];
	assign volt[2] = s_tdata[3*VOLT_BITS-1:2*VOLT_BITS];

	// one lane per phase; each diffs against the next phase
	for (genvar g = 0; g < PHASES; g++) begin : g_lane
		mvm_lane u_lane (
			.volt      (volt[g]),
			.volt_next (volt[(g + 1) % PHASES]),
			.cfg       (cfg_q),
			.res       (lane_c[g])
		);
	end

	// per-stage ready chain
	assign rdy5     = !out_v_q || m_tready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign s_tready = !v_s1 || rdy2;
	assign upd      = v_s4 && rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_tready) v_s1    <= s_tvalid;
			if (rdy2)     v_s2    <= v_s1;
			if (rdy3)     v_s3    <= v_s2;
			if (rdy4)     v_s4    <= v_s3;
			if (rdy5)     out_v_q <= v_s4;
		end
	end

	// average and imbalance base, one multiply per stage
	assign q3   = Q3_W'(sum_s1) * Q3_W'(M3);
	assign q100 = Q100_W'(prod_s3) * Q100_W'(M100);

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			lane_s1 <= lane_c;
			sum_s1  <= SUM_W'(volt[0]) + SUM_W'(volt[1]) + SUM_W'(volt[2]);
		end
		if (rdy2 && v_s1) begin
			lane_s2 <= lane_s1;
			avg_s2  <= q3[S3 +: VOLT_BITS];
		end
		if (rdy3 && v_s2) begin
			lane_s3 <= lane_s2;
			prod_s3 <= PROD_W'(avg_s2) * PROD_W'(cfg_q.imbalance_percent);
		end
		if (rdy4 && v_s3) begin
			lane_s4 <= lane_s3;
			base_s4 <= q100[S100 +: BASE_W];
		end
	end

	// merge lanes with the monitor state
	mvm_merge u_merge (
		.lanes (lane_s4),
		.base  (base_s4),
		.cfg   (cfg_q),
		.cur   (st_q),
		.nxt   (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (upd) begin
			st_q <= st_nxt;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b000, st_q.imbalanced, st_q.phase_fail, st_q.mains_failed};

	// single-phase updates leave the per-phase flags and imbalance alone
	`MVM_ASSERT_NEXT(a_single_hold, clk, arst_n, upd && cfg_q.single_phase,
		$stable(st_q.phase_fail) && $stable(st_q.imbalanced))

	// three-phase: imbalance implies failed mains and no failed phase
	`MVM_ASSERT_NEXT(a_imb_consistent, clk, arst_n, upd && !cfg_q.single_phase,
		(!st_q.imbalanced || st_q.mains_failed) && !(st_q.imbalanced && (|st_q.phase_fail)))

	// a result only appears when the last stage held a request
	`MVM_ASSERT_NOW(a_out_source, clk, arst_n, $rose(out_v_q), $past(v_s4))

endmodule

[hdl/mvm_lane.sv]
`timescale 1ns / 1ps

module mvm_lane
	import mvm_pkg::*;
(
	input  logic [VOLT_BITS-1:0] volt,
	input  logic [VOLT_BITS-1:0] volt_next,
	input  cfg_t                 cfg,
	output lane_res_t            res
);

	logic [CMP_W-1:0] v_ext;
	logic             ov_on;

	assign v_ext = CMP_W'(volt);
	assign ov_on = cfg.overvolt_level < LVL_W'(OVERVOLT_OFF);

	// window compares against both undervolt levels; state picks one later
	always_comb begin
		res.low_fail = v_ext <= CMP_W'(cfg.undervolt_fail_level);
		res.low_rec  = v_ext <= CMP_W'(cfg.undervolt_recover_level);
		res.high     = ov_on && (v_ext >= CMP_W'(cfg.overvolt_level));
		res.diff     = (volt > volt_next) ? (volt - volt_next) : (volt_next - volt);
	end

endmodule

[hdl/mvm_merge.sv]
`timescale 1ns / 1ps

module mvm_merge
	import mvm_pkg::*;
(
	input  lane_res_t         lanes [PHASES],
	input  logic [BASE_W-1:0] base,
	input  cfg_t              cfg,
	input  mvm_state_t        cur,
	output mvm_state_t        nxt
);

	logic [PHASES-1:0] bad;
	logic [PHASES-1:0] over_lim;
	logic [EXT_W-1:0]  base_ext;
	logic [EXT_W-1:0]  tol_ext;
	logic [LIM_W-1:0]  limit;

	// per-phase fail with undervolt hysteresis on the mains state
	always_comb begin
		for (int i = 0; i < PHASES; i++) begin
			bad[i] = (cur.mains_failed ? lanes[i].low_rec : lanes[i].low_fail) | lanes[i].high;
		end
	end

	// imbalance limit, band direction from the current imbalance flag
	assign base_ext = EXT_W'(base);
	assign tol_ext  = EXT_W'(cfg.imb_band);
	assign limit    = cur.imbalanced ? LIM_W'(base_ext - tol_ext) : LIM_W'(base_ext + tol_ext);

	always_comb begin
		for (int i = 0; i < PHASES; i++) begin
			over_lim[i] = LIM_W'(lanes[i].diff) > limit;
		end
	end

	// combine lanes into the next state
	always_comb begin
		nxt = cur;
		if (cfg.single_phase) begin
			nxt.mains_failed = bad[0];
		end else begin
			nxt.phase_fail   = bad;
			nxt.mains_failed = |bad;
			nxt.imbalanced   = 1'b0;
			if (!(|bad) && cfg.imbalance_enable) begin
				nxt.mains_failed = |over_lim;
				nxt.imbalanced   = |over_lim;
			end
		end
	end

endmodule

[tb/sv/mains_voltage_monitor_tb.sv]
`timescale 1ns / 1ps

module mains_voltage_monitor_tb;
	import mvm_pkg::*;

	localparam int RESET_CYCLES = 9;
	localparam int MAX_WAIT     = 12;
	localparam int PIPE_LATENCY = 4;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int REPORT_MAX   = 10;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 85;
	localparam int VOLT_MAX     = (1 << VOLT_BITS) - 1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;  // volt_r, volt_y, volt_b, zero pad
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [7:0]            m_tdata;         // mains_fail, fail_r, fail_y, fail_b, imbalanced, pad

	// predictor copy of registers and monitor state
	cfg_t       cfg_now;
	mvm_state_t mon_state;
	mvm_state_t expected_status_q[$];

	int error_count     = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int cfg_writes      = 0;
	int fails_seen      = 0;
	int imb_seen        = 0;
	int cycle_count     = 0;
	bit idle_on         = 1'b1;

	mains_voltage_monitor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// 4 ns clock
	initial begin
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_status_q.size());
			$display("mains_voltage_monitor test failed");
			$finish;
		end
	end

	function automatic cfg_t reset_cfg();
		cfg_t c;
		c.single_phase            = 1'b0;
		c.imbalance_enable        = 1'b1;
		c.undervolt_fail_level    = 10'd170;
		c.undervolt_recover_level = 10'd180;
		c.overvolt_level          = 10'd270;
		c.imbalance_percent       = 7'd20;
		c.imb_band                = 8'd5;
		return c;
	endfunction

	function automatic int clamp_volt(int v);
		if (v < 0)
			return 0;
		if (v > VOLT_MAX)
			return VOLT_MAX;
		return v;
	endfunction

	function automatic int abs_diff(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// one phase outside its window
	function automatic bit phase_out(int v, int under);
		bit low;
		bit high;
		low  = v <= under;
		high = (v >= int'(cfg_now.overvolt_level)) && (cfg_now.overvolt_level < OVERVOLT_OFF);
		return low || high;
	endfunction

	// advance the monitor model by one sample and queue the status it produces
	task automatic judge_sample(int r, int y, int b);
		int under;
		int avg;
		int base;
		int lim;
		logic [PHASES-1:0] pf;
		under = mon_state.mains_failed ? int'(cfg_now.undervolt_recover_level)
		                               : int'(cfg_now.undervolt_fail_level);
		if (cfg_now.single_phase) begin
			mon_state.mains_failed = phase_out(r, under);
		end else begin
			pf = {phase_out(b, under), phase_out(y, under), phase_out(r, under)};
			mon_state.phase_fail   = pf;
			mon_state.mains_failed = |pf;
			if (!mon_state.mains_failed && cfg_now.imbalance_enable) begin
				avg  = (r + y + b) / PHASES;
				base = (avg * int'(cfg_now.imbalance_percent)) / PERCENT_DIV;
				// limit wraps at 16 bits
				if (mon_state.imbalanced)
					lim = (base - int'(cfg_now.imb_band)) & 32'hFFFF;
				else
					lim = (base + int'(cfg_now.imb_band)) & 32'hFFFF;
				if (abs_diff(r, y) > lim || abs_diff(b, y) > lim || abs_diff(b, r) > lim) begin
					mon_state.mains_failed = 1'b1;
					mon_state.imbalanced   = 1'b1;
				end else begin
					mon_state.imbalanced = 1'b0;
				end
			end else begin
				mon_state.imbalanced = 1'b0;
			end
		end
		expected_status_q.push_back(mon_state);
	endtask

	// send one sample request, predict on accept
	task automatic send_sample(int r, int y, int b);
		int gap;
		// the bus carries VOLT_BITS per phase
		r   = r & VOLT_MAX;
		y   = y & VOLT_MAX;
		b   = b & VOLT_MAX;
		gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'({VOLT_BITS'(b), VOLT_BITS'(y), VOLT_BITS'(r)});
		do @(posedge clk); while (!s_tready);
		judge_sample(r, y, b);
		items_sent++;
	endtask

	// hold off samples until every queued status has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_status_q.size() != 0);
	endtask

	task automatic put_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
	endtask

	// write the full register set while the block is idle
	task automatic write_cfg(cfg_t c);
		wait_idle();
		put_reg(CFG_SINGLE_PHASE,  CFG_DATA_W'(c.single_phase));
		put_reg(CFG_IMB_ENABLE,    CFG_DATA_W'(c.imbalance_enable));
		put_reg(CFG_UV_FAIL,       CFG_DATA_W'(c.undervolt_fail_level));
		put_reg(CFG_UV_RECOVER,    CFG_DATA_W'(c.undervolt_recover_level));
		put_reg(CFG_OVERVOLT,      CFG_DATA_W'(c.overvolt_level));
		put_reg(CFG_IMB_PERCENT,   CFG_DATA_W'(c.imbalance_percent));
		put_reg(CFG_IMB_TOLERANCE, CFG_DATA_W'(c.imb_band));
		cfg_valid <= 1'b0;
		cfg_now = c;
	endtask

	// result side: random stalls, compare against oldest prediction
	initial begin
		mvm_state_t got;
		mvm_state_t want;
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = mvm_state_t'(m_tdata[4:0]);
			results_checked++;
			if (got.mains_failed)
				fails_seen++;
			if (got.imbalanced)
				imb_seen++;
			if (expected_status_q.size() == 0) begin
				if (error_count < REPORT_MAX)
					$display("%0t: status with no request pending: %b", $time, m_tdata);
				error_count++;
			end else begin
				want = expected_status_q.pop_front();
				if (got.mains_failed !== want.mains_failed || got.phase_fail !== want.phase_fail
					|| got.imbalanced !== want.imbalanced) begin
					if (error_count < REPORT_MAX)
						$display({"%0t: status mismatch: expected mains=%b r/y/b=%b%b%b imb=%b,",
							" got mains=%b r/y/b=%b%b%b imb=%b"}, $time, want.mains_failed,
							want.phase_fail[0], want.phase_fail[1], want.phase_fail[2],
							want.imbalanced, got.mains_failed, got.phase_fail[0],
							got.phase_fail[1], got.phase_fail[2], got.imbalanced);
					error_count++;
				end
			end
		end
	end

	// thresholds, hysteresis and per-phase flags at reset settings
	task automatic test_defaults();
		send_sample(230, 230, 230);
		send_sample(0, 0, 0);
		// failed: recover level applies
		send_sample(175, 230, 230);
		send_sample(180, 230, 230);
		send_sample(181, 200, 200);
		// healthy: fail level applies
		send_sample(171, 200, 200);
		send_sample(170, 200, 200);
		send_sample(VOLT_MAX, VOLT_MAX, VOLT_MAX);
		send_sample(269, 269, 269);
		send_sample(270, 260, 260);
		// imbalance set, then held by the narrower limit
		send_sample(240, 240, 185);
		send_sample(240, 240, 195);
		send_sample(230, 230, 230);
		send_sample(230, 0, 230);
		send_sample(230, 230, VOLT_MAX);
	endtask

	// only R decides, phase and imbalance flags hold
	task automatic test_single_phase();
		cfg_t c;
		c = reset_cfg();
		c.single_phase = 1'b1;
		write_cfg(c);
		send_sample(230, 0, VOLT_MAX);
		send_sample(100, 230, 230);
	endtask

	// overvolt check switched off at 500 and above, on below
	task automatic test_overvolt_off();
		cfg_t c;
		c = reset_cfg();
		c.overvolt_level = 10'd500;
		write_cfg(c);
		send_sample(VOLT_MAX, VOLT_MAX, VOLT_MAX);
		c.overvolt_level = 10'd499;
		write_cfg(c);
		send_sample(499, 499, 499);
		c.overvolt_level = 10'd0;
		write_cfg(c);
		send_sample(600, 600, 600);
	endtask

	// tolerance subtracted below zero wraps to a huge limit
	task automatic test_limit_wrap();
		cfg_t c;
		c = reset_cfg();
		c.overvolt_level    = 10'd1023;
		c.imbalance_percent = 7'd0;
		c.imb_band          = 8'd0;
		write_cfg(c);
		send_sample(230, 231, 230);
		c.imb_band = 8'd255;
		write_cfg(c);
		send_sample(230, 1000, 230);
	endtask

	// detection disabled, then percent above 100
	task automatic test_imbalance_enable();
		cfg_t c;
		c = reset_cfg();
		c.overvolt_level   = 10'd1023;
		c.imbalance_enable = 1'b0;
		write_cfg(c);
		send_sample(230, 600, 230);
		c.imbalance_enable  = 1'b1;
		c.imbalance_percent = 7'd127;
		c.imb_band          = 8'd0;
		write_cfg(c);
		send_sample(230, 600, 230);
		send_sample(200, 1000, 200);
	endtask

	// register set for one random phase; a few fixed extremes
	function automatic cfg_t phase_cfg(int p);
		cfg_t c;
		int uvf;
		uvf = $urandom_range(100, 220);
		c.single_phase            = ($urandom_range(0, 3) == 0);
		c.imbalance_enable        = ($urandom_range(0, 3) != 0);
		c.undervolt_fail_level    = 10'(uvf);
		c.undervolt_recover_level = 10'(uvf + $urandom_range(0, 30));
		c.overvolt_level          = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(500, 1023))
		                                                        : 10'($urandom_range(240, 320));
		c.imbalance_percent       = 7'($urandom_range(0, 127));
		c.imb_band                = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
		                                                        : 8'($urandom_range(0, 20));
		case (p)
			0: begin
				c = reset_cfg();
			end
			1: begin
				c.single_phase            = 1'b0;
				c.imbalance_enable        = 1'b1;
				c.undervolt_fail_level    = 10'd0;
				c.undervolt_recover_level = 10'd0;
				c.overvolt_level          = 10'd1023;
				c.imbalance_percent       = 7'd0;
				c.imb_band                = 8'd0;
			end
			2: begin
				c.single_phase            = 1'b0;
				c.imbalance_enable        = 1'b1;
				c.undervolt_fail_level    = 10'd0;
				c.undervolt_recover_level = 10'd1023;
				c.overvolt_level          = 10'd499;
				c.imbalance_percent       = 7'd127;
				c.imb_band                = 8'd255;
			end
			3: begin
				c.single_phase = 1'b1;
			end
			4: begin
				c.single_phase            = 1'b0;
				c.imbalance_enable        = 1'b0;
				c.undervolt_fail_level    = 10'd1023;
				c.undervolt_recover_level = 10'd0;
				c.overvolt_level          = 10'd500;
				c.imbalance_percent       = 7'd100;
				c.imb_band                = 8'd128;
			end
			default: begin
			end
		endcase
		return c;
	endfunction

	// runs of samples clustered near a level so hysteresis gets walked both ways
	task automatic test_random();
		int n;
		int run;
		int anchor;
		int kind;
		int r;
		int y;
		int b;
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_cfg(phase_cfg(p));
			idle_on = (p % 3 != 1);
			n = 0;
			while (n < PHASE_ITEMS) begin
				run = $urandom_range(1, 8);
				case ($urandom_range(0, 4))
					0: anchor = cfg_now.undervolt_fail_level;
					1: anchor = cfg_now.undervolt_recover_level;
					2: anchor = (cfg_now.overvolt_level < OVERVOLT_OFF) ? cfg_now.overvolt_level : 230;
					3: anchor = $urandom_range(150, 300);
					default: anchor = $urandom_range(0, VOLT_MAX);
				endcase
				repeat (run) begin
					kind = $urandom_range(0, 7);
					if (kind == 0) begin
						r = $urandom_range(0, VOLT_MAX);
						y = $urandom_range(0, VOLT_MAX);
						b = $urandom_range(0, VOLT_MAX);
					end else begin
						r = clamp_volt(anchor + int'($urandom_range(0, 24)) - 12);
						y = clamp_volt(anchor + int'($urandom_range(0, 24)) - 12);
						b = clamp_volt(anchor + int'($urandom_range(0, 24)) - 12);
						// skew one phase for imbalance
						if (kind == 1) begin
							case ($urandom_range(0, 2))
								0: r = clamp_volt(r + int'($urandom_range(0, 300)) - 150);
								1: y = clamp_volt(y + int'($urandom_range(0, 300)) - 150);
								default: b = clamp_volt(b + int'($urandom_range(0, 300)) - 150);
							endcase
						end
					end
					send_sample(r, y, b);
					n++;
				end
			end
		end
		idle_on = 1'b1;
	endtask

	// sequence
	initial begin
		cfg_now   = reset_cfg();
		mon_state = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_single_phase();
		test_overvolt_off();
		test_limit_wrap();
		test_imbalance_enable();
		test_random();
		wait_idle();
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		$display("covered %0d samples and %0d register writes over %0d settings, %0d results",
			items_sent, cfg_writes, RAND_PHASES + 9, results_checked);
		$display("%0d results showed mains failure, %0d showed imbalance, %0d errors",
			fails_seen, imb_seen, error_count + expected_status_q.size());
		if (error_count == 0 && expected_status_q.size() == 0)
			$display("mains_voltage_monitor test passed");
		else
			$display("mains_voltage_monitor test failed");
		$finish;
	end

endmodule
